// File: sv/gfas_pkg.sv
// gfas_pkg: item types, codes and fixed-point constants for the feature grid index
// used by the channel interfaces and by grid_feature_area_search
package gfas_pkg;

  // opcodes of an input item
  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // configuration register indexes
  localparam logic [1:0] REG_ORIGIN_X   = 2'd0;
  localparam logic [1:0] REG_ORIGIN_Y   = 2'd1;
  localparam logic [1:0] REG_INV_CELL_W = 2'd2;
  localparam logic [1:0] REG_INV_CELL_H = 2'd3;

  // reset value of the inverse cell sizes, unsigned Q0.20 held in 16 bits
  localparam logic [15:0] INV_CELL_RESET = 16'd6554;

  // fraction bits of a cell coordinate product
  localparam int FRAC = 20;

  typedef enum logic [2:0] {
    ST_HIT        = 3'd0,
    ST_HIT_TRUNC  = 3'd1,
    ST_NO_HITS    = 3'd2,
    ST_INSERTED   = 3'd3,
    ST_OUTSIDE    = 3'd4,
    ST_CELL_FULL  = 3'd5,
    ST_STORE_FULL = 3'd6
  } status_t;

  typedef struct packed {
    logic [1:0]         opcode;
    logic signed [15:0] coord_x;
    logic signed [15:0] coord_y;
    logic [2:0]         level;
    logic [15:0]        radius;
    logic [2:0]         min_level;
    logic signed [3:0]  max_level;
  } in_item_t;

  typedef struct packed {
    logic [9:0] feature_index;
    status_t    status;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic [1:0]  index;
    logic [15:0] data;
  } cfg_item_t;

endpackage

// File: sv/gfas_if.sv
// gfas channel interfaces: request, result and configuration write
// depends on gfas_pkg for the payload types
interface gfas_in_if;
  logic               valid;
  logic               ready;
  gfas_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface gfas_out_if;
  logic                valid;
  logic                ready;
  gfas_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface gfas_cfg_if;
  logic                valid;
  logic                ready;
  gfas_pkg::cfg_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: sv/gfas_ram.sv
// gfas_ram: generic single write port, single read port ram with registered read
// no dependencies
module gfas_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: sv/grid_feature_area_search.sv
// grid_feature_area_search: uniform grid index of feature points with box queries
// depends on gfas_pkg, gfas_if channel interfaces and gfas_ram
//
// After reset, and after every clear item, the block sweeps the cell fill table once
// and takes no item meanwhile; configuration writes are taken at any time. One signed
// multiplier, registered, is shared under a sequencer for every cell coordinate and
// address product, and the stores are rams with one write and one read port, read one
// word a cycle. An insert stores the point, computes its cell and, if the cell has room,
// files the entry and counts up the fill before its result; a store-full insert goes
// straight to its result. A query computes its box, then reads the fill of each visited
// cell and tests each filed entry, a hit waiting on a busy output; an empty box goes
// straight to the final result. Results sit in an output register, one item at a time.
module grid_feature_area_search #(
  parameter int GRID_COLS  = 64,
  parameter int GRID_ROWS  = 48,
  parameter int CELL_DEPTH = 8,
  parameter int MAX_POINTS = 1024,
  parameter int MAX_HITS   = 64
) (
  input logic       clk,
  input logic       rst,
  gfas_in_if.sink   req,
  gfas_out_if.source rsp,
  gfas_cfg_if.sink  cfg
);
  import gfas_pkg::*;

  localparam int NCELLS = GRID_COLS * GRID_ROWS;
  localparam int NENT   = NCELLS * CELL_DEPTH;
  localparam int CW     = GRID_COLS > 1 ? $clog2(GRID_COLS) : 1;
  localparam int RWW    = GRID_ROWS > 1 ? $clog2(GRID_ROWS) : 1;
  localparam int CAW    = NCELLS > 1 ? $clog2(NCELLS) : 1;
  localparam int EAW    = NENT > 1 ? $clog2(NENT) : 1;
  localparam int FW     = $clog2(CELL_DEPTH + 1);
  localparam int IW     = $clog2(MAX_POINTS);
  localparam int PCW    = $clog2(MAX_POINTS + 1);
  localparam int HW     = $clog2(MAX_HITS + 1);
  localparam int QW     = 16;
  localparam int PW     = 35;
  localparam logic signed [PW-1:0] HALF   = PW'(64'sd1 <<< (FRAC - 1));
  localparam logic signed [PW-1:0] ONE_M1 = PW'((64'sd1 <<< FRAC) - 1);

  typedef enum logic [23:0] {
    S_CLR   = 24'd1 << 0,
    S_IDLE  = 24'd1 << 1,
    S_IMX   = 24'd1 << 2,
    S_IMY   = 24'd1 << 3,
    S_ICELL = 24'd1 << 4,
    S_IADDR = 24'd1 << 5,
    S_IFILL = 24'd1 << 6,
    S_IEB   = 24'd1 << 7,
    S_PUT   = 24'd1 << 8,
    S_QX0   = 24'd1 << 9,
    S_QX1   = 24'd1 << 10,
    S_QY0   = 24'd1 << 11,
    S_QY1   = 24'd1 << 12,
    S_QBOX  = 24'd1 << 13,
    S_QBASE = 24'd1 << 14,
    S_QEB   = 24'd1 << 15,
    S_QCELL = 24'd1 << 16,
    S_QFILL = 24'd1 << 17,
    S_QENT  = 24'd1 << 18,
    S_QPT   = 24'd1 << 19,
    S_QHIT  = 24'd1 << 20,
    S_QADV  = 24'd1 << 21,
    S_QNEXT = 24'd1 << 22,
    S_QEND  = 24'd1 << 23
  } state_t;

  state_t state, state_next;

  // configuration registers
  logic signed [15:0] origin_x, origin_y;
  logic [15:0]        inv_cell_width, inv_cell_height;

  // latched item fields
  logic signed [15:0] cx, cy;
  logic [15:0]        rad;
  logic [2:0]         lvl, minl;
  logic signed [3:0]  maxl;

  // control and datapath registers
  logic [PCW-1:0]        point_count;
  logic [CAW-1:0]        clr_addr;
  logic signed [PW-1:0]  prod;
  logic signed [QW-1:0]  colq, rowr, c0f, c1f, r0f;
  logic [CW-1:0]         c1c, cur_col;
  logic [RWW-1:0]        r0c, r1c, cur_row;
  logic [CAW-1:0]        cur_cell, cstart;
  logic [EAW-1:0]        cur_eb, estart;
  logic [FW-1:0]         filr, jj;
  logic [IW-1:0]         ins_idx, idx_r, pend_idx, res_idx;
  logic                  pend_valid;
  logic [HW-1:0]         hits;
  status_t               res_st;
  logic                  o_valid;
  out_item_t             o_data;

  // multiplier operands
  logic signed [17:0] ma;
  logic signed [16:0] mb;

  // ram ports
  logic              fill_we;
  logic [CAW-1:0]    fill_waddr, fill_raddr;
  logic [FW-1:0]     fill_wdata, fill_q;
  logic              ent_we;
  logic [EAW-1:0]    ent_waddr, ent_raddr;
  logic [IW-1:0]     ent_q;
  logic              pt_we;
  logic [IW-1:0]     pt_raddr;
  logic [34:0]       pt_q;

  // result hand-off
  logic          can_put, put, put_last;
  logic [IW-1:0] put_idx;
  status_t       put_st;

  // derived values
  logic signed [16:0]   dxa, dya;
  logic signed [17:0]   rr;
  logic signed [QW-1:0] p_floor, p_ceil, p_round;
  logic signed [PW-1:0] p_ceil_sum, p_round_sum;
  logic                 box_empty, col_out, row_out;
  logic [CAW-1:0]       cell_ins, cell_base, cell_next, cstart_next;
  logic [EAW-1:0]       eb_next, estart_next;
  logic [FW-1:0]        jnext;
  logic signed [16:0]   ex, ey;
  logic [16:0]          ax, ay;
  logic                 pt_match;

  gfas_ram #(.WIDTH(FW), .DEPTH(NCELLS)) u_fill (
    .clk(clk), .we(fill_we), .waddr(fill_waddr), .wdata(fill_wdata),
    .raddr(fill_raddr), .rdata(fill_q)
  );

  gfas_ram #(.WIDTH(IW), .DEPTH(NENT)) u_entries (
    .clk(clk), .we(ent_we), .waddr(ent_waddr), .wdata(ins_idx),
    .raddr(ent_raddr), .rdata(ent_q)
  );

  gfas_ram #(.WIDTH(35), .DEPTH(MAX_POINTS)) u_points (
    .clk(clk), .we(pt_we), .waddr(ins_idx), .wdata({cx, cy, lvl}),
    .raddr(pt_raddr), .rdata(pt_q)
  );

  // offsets from the grid origin and rounding of the shared product
  always_comb begin
    dxa         = 17'(cx) - 17'(origin_x);
    dya         = 17'(cy) - 17'(origin_y);
    rr          = signed'({2'b00, rad});
    p_floor     = QW'(prod >>> FRAC);
    p_ceil_sum  = prod + ONE_M1;
    p_ceil      = QW'(p_ceil_sum >>> FRAC);
    p_round_sum = prod + HALF;
    if (prod[PW-1]) begin
      p_round = (prod > -HALF) ? QW'(0) : -QW'(1);
    end else begin
      p_round = QW'(p_round_sum >>> FRAC);
    end
  end

  // grid range tests
  always_comb begin
    col_out   = colq[QW-1] || (colq >= QW'(GRID_COLS));
    row_out   = p_round[QW-1] || (p_round >= QW'(GRID_ROWS));
    box_empty = (c0f >= QW'(GRID_COLS)) || c1f[QW-1] ||
                (r0f >= QW'(GRID_ROWS)) || p_ceil[QW-1];
  end

  // walk address arithmetic
  always_comb begin
    cell_ins    = prod[CAW-1:0] + CAW'(unsigned'(rowr));
    cell_base   = prod[CAW-1:0] + CAW'(r0c);
    cstart_next = cstart + CAW'(GRID_ROWS);
    estart_next = estart + EAW'(GRID_ROWS * CELL_DEPTH);
    if (cur_row < r1c) begin
      cell_next = cur_cell + CAW'(1);
      eb_next   = cur_eb + EAW'(CELL_DEPTH);
    end else begin
      cell_next = cstart_next;
      eb_next   = estart_next;
    end
    jnext = jj + FW'(1);
  end

  // point test against the query window
  always_comb begin
    ex       = 17'(signed'(pt_q[34:19])) - 17'(cx);
    ey       = 17'(signed'(pt_q[18:3])) - 17'(cy);
    ax       = ex[16] ? unsigned'(-ex) : unsigned'(ex);
    ay       = ey[16] ? unsigned'(-ey) : unsigned'(ey);
    pt_match = (pt_q[2:0] >= minl) && (maxl[3] || (pt_q[2:0] <= unsigned'(maxl[2:0]))) &&
               (ax < {1'b0, rad}) && (ay < {1'b0, rad});
  end

  assign can_put = !o_valid || rsp.ready;

  // sequencer: next state, multiplier operands, memory ports, results
  always_comb begin
    state_next = state;
    ma         = '0;
    mb         = '0;
    fill_we    = 1'b0;
    fill_waddr = cur_cell;
    fill_wdata = '0;
    fill_raddr = cur_cell;
    ent_we     = 1'b0;
    ent_waddr  = prod[EAW-1:0] + EAW'(filr);
    ent_raddr  = cur_eb;
    pt_we      = 1'b0;
    pt_raddr   = ent_q;
    put        = 1'b0;
    put_idx    = res_idx;
    put_st     = res_st;
    put_last   = 1'b1;
    case (state)
      S_CLR: begin
        fill_we    = 1'b1;
        fill_waddr = clr_addr;
        if (clr_addr == CAW'(NCELLS - 1)) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (req.valid) begin
          case (req.data.opcode)
            OP_CLEAR:  state_next = S_CLR;
            OP_INSERT: state_next = (point_count >= PCW'(MAX_POINTS)) ? S_PUT : S_IMX;
            OP_QUERY:  state_next = S_QX0;
            default:   state_next = S_IDLE;
          endcase
        end
      end
      S_IMX: begin
        pt_we      = 1'b1;
        ma         = 18'(dxa);
        mb         = signed'({1'b0, inv_cell_width});
        state_next = S_IMY;
      end
      S_IMY: begin
        ma         = 18'(dya);
        mb         = signed'({1'b0, inv_cell_height});
        state_next = S_ICELL;
      end
      S_ICELL: begin
        ma         = 18'(colq);
        mb         = 17'(GRID_ROWS);
        state_next = (col_out || row_out) ? S_PUT : S_IADDR;
      end
      S_IADDR: begin
        fill_raddr = cell_ins;
        state_next = S_IFILL;
      end
      S_IFILL: begin
        ma         = signed'(18'(cur_cell));
        mb         = 17'(CELL_DEPTH);
        state_next = (fill_q >= FW'(CELL_DEPTH)) ? S_PUT : S_IEB;
      end
      S_IEB: begin
        ent_we     = 1'b1;
        fill_we    = 1'b1;
        fill_wdata = filr + FW'(1);
        state_next = S_PUT;
      end
      S_PUT: begin
        if (can_put) begin
          put        = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_QX0: begin
        ma         = 18'(dxa) - rr;
        mb         = signed'({1'b0, inv_cell_width});
        state_next = S_QX1;
      end
      S_QX1: begin
        ma         = 18'(dxa) + rr;
        mb         = signed'({1'b0, inv_cell_width});
        state_next = S_QY0;
      end
      S_QY0: begin
        ma         = 18'(dya) - rr;
        mb         = signed'({1'b0, inv_cell_height});
        state_next = S_QY1;
      end
      S_QY1: begin
        ma         = 18'(dya) + rr;
        mb         = signed'({1'b0, inv_cell_height});
        state_next = S_QBOX;
      end
      S_QBOX: begin
        // first column of the box, clamped at the left edge
        ma         = c0f[QW-1] ? 18'sd0 : 18'(c0f);
        mb         = 17'(GRID_ROWS);
        state_next = box_empty ? S_QEND : S_QBASE;
      end
      S_QBASE: state_next = S_QEB;
      S_QEB: begin
        ma         = signed'(18'(cstart));
        mb         = 17'(CELL_DEPTH);
        state_next = S_QCELL;
      end
      S_QCELL: begin
        fill_raddr = cur_cell;
        state_next = S_QFILL;
      end
      S_QFILL: begin
        ent_raddr  = cur_eb;
        state_next = (fill_q == '0) ? S_QNEXT : S_QENT;
      end
      S_QENT: begin
        pt_raddr   = ent_q;
        state_next = S_QPT;
      end
      S_QPT: state_next = pt_match ? S_QHIT : S_QADV;
      S_QHIT: begin
        put_idx = pend_idx;
        if (hits == HW'(MAX_HITS)) begin
          put_st = ST_HIT_TRUNC;
          if (can_put) begin
            put        = 1'b1;
            state_next = S_IDLE;
          end
        end else if (pend_valid) begin
          put_st   = ST_HIT;
          put_last = 1'b0;
          if (can_put) begin
            put        = 1'b1;
            state_next = S_QADV;
          end
        end else begin
          state_next = S_QADV;
        end
      end
      S_QADV: begin
        ent_raddr  = cur_eb + EAW'(jnext);
        state_next = (jnext < filr) ? S_QENT : S_QNEXT;
      end
      S_QNEXT: begin
        fill_raddr = cell_next;
        if (cur_row < r1c || cur_col < c1c) state_next = S_QFILL;
        else state_next = S_QEND;
      end
      S_QEND: begin
        put_idx = pend_valid ? pend_idx : '0;
        put_st  = pend_valid ? ST_HIT : ST_NO_HITS;
        if (can_put) begin
          put        = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // state, configuration and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_CLR;
      clr_addr        <= '0;
      point_count     <= '0;
      origin_x        <= '0;
      origin_y        <= '0;
      inv_cell_width  <= INV_CELL_RESET;
      inv_cell_height <= INV_CELL_RESET;
      o_valid         <= 1'b0;
      pend_valid      <= 1'b0;
      hits            <= '0;
    end else begin
      state <= state_next;
      if (cfg.valid) begin
        case (cfg.data.index)
          REG_ORIGIN_X:   origin_x        <= signed'(cfg.data.data);
          REG_ORIGIN_Y:   origin_y        <= signed'(cfg.data.data);
          REG_INV_CELL_W: inv_cell_width  <= cfg.data.data;
          REG_INV_CELL_H: inv_cell_height <= cfg.data.data;
          default: ;
        endcase
      end
      if (put) o_valid <= 1'b1;
      else if (rsp.ready) o_valid <= 1'b0;
      case (state)
        S_CLR: clr_addr <= clr_addr + CAW'(1);
        S_IDLE: begin
          if (req.valid && req.data.opcode == OP_CLEAR) begin
            point_count <= '0;
            clr_addr    <= '0;
          end
          hits       <= '0;
          pend_valid <= 1'b0;
        end
        S_IMX: point_count <= point_count + PCW'(1);
        S_QHIT: begin
          if (hits != HW'(MAX_HITS) && (!pend_valid || can_put)) begin
            pend_valid <= 1'b1;
            hits       <= hits + HW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    prod <= PW'(ma * mb);
    if (put) begin
      o_data.feature_index <= 10'(put_idx);
      o_data.status        <= put_st;
      o_data.last          <= put_last;
    end
    case (state)
      S_IDLE: begin
        cx      <= req.data.coord_x;
        cy      <= req.data.coord_y;
        lvl     <= req.data.level;
        rad     <= req.data.radius;
        minl    <= req.data.min_level;
        maxl    <= req.data.max_level;
        ins_idx <= IW'(point_count);
        res_idx <= '0;
        res_st  <= ST_STORE_FULL;
      end
      S_IMY: colq <= p_round;
      S_ICELL: begin
        rowr    <= p_round;
        res_idx <= ins_idx;
        res_st  <= ST_OUTSIDE;
      end
      S_IADDR: cur_cell <= cell_ins;
      S_IFILL: begin
        filr   <= fill_q;
        res_st <= (fill_q >= FW'(CELL_DEPTH)) ? ST_CELL_FULL : ST_INSERTED;
      end
      S_QX1: c0f <= p_floor;
      S_QY0: c1f <= p_ceil;
      S_QY1: r0f <= p_floor;
      S_QBOX: begin
        c1c     <= (c1f > QW'(GRID_COLS - 1)) ? CW'(GRID_COLS - 1) : CW'(c1f);
        r0c     <= r0f[QW-1] ? '0 : RWW'(r0f);
        r1c     <= (p_ceil > QW'(GRID_ROWS - 1)) ? RWW'(GRID_ROWS - 1) : RWW'(p_ceil);
        cur_col <= c0f[QW-1] ? '0 : CW'(c0f);
        cur_row <= r0f[QW-1] ? '0 : RWW'(r0f);
      end
      S_QBASE: begin
        cstart   <= cell_base;
        cur_cell <= cell_base;
      end
      S_QCELL: begin
        estart <= prod[EAW-1:0];
        cur_eb <= prod[EAW-1:0];
      end
      S_QFILL: begin
        filr <= fill_q;
        jj   <= '0;
      end
      S_QENT: idx_r <= ent_q;
      S_QHIT: begin
        if (hits != HW'(MAX_HITS) && (!pend_valid || can_put)) pend_idx <= idx_r;
      end
      S_QADV: jj <= jnext;
      S_QNEXT: begin
        cur_cell <= cell_next;
        cur_eb   <= eb_next;
        if (cur_row < r1c) begin
          cur_row <= cur_row + RWW'(1);
        end else begin
          cur_row <= r0c;
          cur_col <= cur_col + CW'(1);
          cstart  <= cstart_next;
          estart  <= estart_next;
        end
      end
      default: ;
    endcase
  end

  assign req.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;
  assign rsp.valid = o_valid;
  assign rsp.data  = o_data;

`ifndef NO_ASSERTIONS
  a_pend_counted: assert property (@(posedge clk) disable iff (rst)
    pend_valid |-> hits != '0)
    else $error("pending hit without a hit count");
  a_hits_bound: assert property (@(posedge clk) disable iff (rst)
    hits <= HW'(MAX_HITS))
    else $error("hit count above limit");
  a_no_accept_mid_query: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.data.last |-> !req.ready)
    else $error("input taken before the final result of a query");
  a_put_into_free_slot: assert property (@(posedge clk) disable iff (rst)
    put |-> can_put)
    else $error("result loaded over a waiting result");
`endif

endmodule

// File: tb/tb_grid_feature_area_search.sv
// testbench for grid_feature_area_search: directed and random insert, clear and area query
// items checked against an in-bench predictor; depends on gfas_pkg and the gfas_if interfaces
module tb_grid_feature_area_search;
  import gfas_pkg::*;

  localparam int COLS      = 64;
  localparam int ROWS      = 48;
  localparam int DEPTH     = 8;
  localparam int NPOINTS   = 1024;
  localparam int HIT_LIMIT = 64;
  localparam int IDLE_LIMIT = 60000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  gfas_in_if  req_ch ();
  gfas_out_if rsp_ch ();
  gfas_cfg_if cfg_ch ();

  grid_feature_area_search u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  // clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predictor copy of configuration and stores
  logic signed [15:0] org_x, org_y;
  logic [15:0]        inv_w, inv_h;
  int unsigned        pt_count;
  logic signed [15:0] pt_x [NPOINTS];
  logic signed [15:0] pt_y [NPOINTS];
  logic [2:0]         pt_lvl [NPOINTS];
  int unsigned        fill [COLS*ROWS];
  int unsigned        entry [COLS*ROWS*DEPTH];

  out_item_t expected_q [$];
  int errors = 0;
  int n_items = 0, n_results = 0, n_hits = 0, n_trunc = 0, n_full = 0, n_outside = 0;
  bit steady = 0;  // no idling on either side while set

  // rounding of a value with 20 fraction bits
  function automatic longint round_cell(longint p);
    if (p >= 0) return (p + (64'sd1 << 19)) >>> 20;
    return -((-p + (64'sd1 << 19)) >>> 20);
  endfunction

  function automatic longint floor_cell(longint p);
    if (p >= 0) return p >>> 20;
    return -((-p + (64'sd1 << 20) - 1) >>> 20);
  endfunction

  function automatic longint ceil_cell(longint p);
    if (p >= 0) return (p + (64'sd1 << 20) - 1) >>> 20;
    return -((-p) >>> 20);
  endfunction

  // gap length: mostly short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 40) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // append one expected result
  task automatic queue_expected(out_item_t item);
    expected_q.insert(expected_q.size(), item);
  endtask

  // insert predictor
  task automatic predict_insert(in_item_t it);
    longint col, row;
    int unsigned idx, cell_no;
    if (pt_count >= NPOINTS) begin
      queue_expected(out_item_t'{feature_index: '0, status: ST_STORE_FULL, last: 1'b1});
      n_full++;
      return;
    end
    idx = pt_count;
    pt_x[idx] = it.coord_x;
    pt_y[idx] = it.coord_y;
    pt_lvl[idx] = it.level;
    pt_count++;
    col = round_cell((longint'(it.coord_x) - longint'(org_x)) * longint'(inv_w));
    row = round_cell((longint'(it.coord_y) - longint'(org_y)) * longint'(inv_h));
    if (col < 0 || col >= COLS || row < 0 || row >= ROWS) begin
      queue_expected(out_item_t'{feature_index: idx[9:0], status: ST_OUTSIDE, last: 1'b1});
      n_outside++;
      return;
    end
    cell_no = int'(col * ROWS + row);
    if (fill[cell_no] >= DEPTH) begin
      queue_expected(out_item_t'{feature_index: idx[9:0], status: ST_CELL_FULL, last: 1'b1});
      n_full++;
      return;
    end
    entry[cell_no*DEPTH + fill[cell_no]] = idx;
    fill[cell_no]++;
    queue_expected(out_item_t'{feature_index: idx[9:0], status: ST_INSERTED, last: 1'b1});
  endtask

  // area query predictor
  task automatic predict_query(in_item_t it);
    longint cx, cy, rad, dx, dy, c0, c1, r0, r1, maxl, ex, ey;
    int unsigned cell_no, idx;
    out_item_t hits [$];
    bit done;
    cx = it.coord_x;
    cy = it.coord_y;
    rad = longint'(it.radius);
    maxl = longint'(it.max_level);
    dx = cx - longint'(org_x);
    dy = cy - longint'(org_y);
    done = 0;
    c0 = floor_cell((dx - rad) * longint'(inv_w));
    c1 = ceil_cell((dx + rad) * longint'(inv_w));
    r0 = floor_cell((dy - rad) * longint'(inv_h));
    r1 = ceil_cell((dy + rad) * longint'(inv_h));
    if (c0 < 0) c0 = 0;
    if (r0 < 0) r0 = 0;
    if (c1 > COLS - 1) c1 = COLS - 1;
    if (r1 > ROWS - 1) r1 = ROWS - 1;
    if (!(c0 >= COLS || c1 < 0 || r0 >= ROWS || r1 < 0)) begin
      for (longint c = c0; c <= c1 && !done; c++) begin
        for (longint w = r0; w <= r1 && !done; w++) begin
          cell_no = int'(c * ROWS + w);
          for (int j = 0; j < fill[cell_no] && !done; j++) begin
            idx = entry[cell_no*DEPTH + j];
            if (pt_lvl[idx] < it.min_level) continue;
            if (maxl >= 0 && longint'(pt_lvl[idx]) > maxl) continue;
            ex = longint'(pt_x[idx]) - cx;
            ey = longint'(pt_y[idx]) - cy;
            if (ex < 0) ex = -ex;
            if (ey < 0) ey = -ey;
            if (!(ex < rad && ey < rad)) continue;
            if (hits.size() >= HIT_LIMIT) begin
              hits[$].status = ST_HIT_TRUNC;
              n_trunc++;
              done = 1;
            end else begin
              hits.insert(hits.size(),
                          out_item_t'{feature_index: idx[9:0], status: ST_HIT, last: 1'b0});
            end
          end
        end
      end
    end
    if (hits.size() == 0) begin
      queue_expected(out_item_t'{feature_index: '0, status: ST_NO_HITS, last: 1'b1});
      return;
    end
    hits[$].last = 1'b1;
    n_hits += hits.size();
    foreach (hits[k]) queue_expected(hits[k]);
  endtask

  // send one item and predict at acceptance
  task automatic send_item(in_item_t it);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.data  <= it;
    do @(posedge clk); while (!req_ch.ready);
    n_items++;
    case (it.opcode)
      OP_CLEAR: begin
        foreach (fill[k]) fill[k] = 0;
        pt_count = 0;
      end
      OP_INSERT: predict_insert(it);
      OP_QUERY:  predict_query(it);
      default: ;
    endcase
  endtask

  // drop valid and wait until every expected result has come out
  task automatic drain();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] index, logic [15:0] value);
    drain();
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= '{index: index, data: value};
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    case (index)
      REG_ORIGIN_X:   org_x = value;
      REG_ORIGIN_Y:   org_y = value;
      REG_INV_CELL_W: inv_w = value;
      default:        inv_h = value;
    endcase
  endtask

  task automatic set_grid(logic [15:0] ox, logic [15:0] oy, logic [15:0] iw, logic [15:0] ih);
    write_reg(REG_ORIGIN_X, ox);
    write_reg(REG_ORIGIN_Y, oy);
    write_reg(REG_INV_CELL_W, iw);
    write_reg(REG_INV_CELL_H, ih);
  endtask

  function automatic in_item_t mk(logic [1:0] op, int x, int y, int lvl = 0, int rad = 0,
                                  int minl = 0, int maxl = -1);
    in_item_t it;
    it.opcode = op;
    it.coord_x = x[15:0];
    it.coord_y = y[15:0];
    it.level = lvl[2:0];
    it.radius = rad[15:0];
    it.min_level = minl[2:0];
    it.max_level = maxl[3:0];
    return it;
  endfunction

  // coordinate spread over the grid for the current setting, with some margin
  function automatic int grid_coord(logic signed [15:0] org, logic [15:0] inv, int cells);
    longint span;
    span = (inv == 0) ? 65535 : ((longint'(cells) << 20) / inv);
    if (span > 65535) span = 65535;
    return int'(org) - 8 + int'($urandom_range(0, int'(span) + 16));
  endfunction

  function automatic int cell_pitch();
    return (inv_w == 0) ? 65535 : ((1 << 20) / inv_w > 65535 ? 65535 : (1 << 20) / inv_w);
  endfunction

  function automatic in_item_t rand_insert();
    return mk(OP_INSERT, grid_coord(org_x, inv_w, COLS), grid_coord(org_y, inv_h, ROWS),
              $urandom_range(0, 7));
  endfunction

  function automatic in_item_t rand_query(bit wide);
    int rad;
    rad = wide ? $urandom_range(0, 65535) : $urandom_range(0, 3 * cell_pitch());
    return mk(OP_QUERY, grid_coord(org_x, inv_w, COLS), grid_coord(org_y, inv_h, ROWS),
              0, rad, $urandom_range(0, 7), $urandom_range(0, 15) - 8);
  endfunction

  // mismatch report
  task automatic report(string what, int got, int want);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  // result checker
  always @(posedge clk) begin
    out_item_t exp_item;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      n_results++;
      if (expected_q.size() == 0) begin
        report("unexpected result, index", rsp_ch.data.feature_index, -1);
      end else begin
        exp_item = expected_q.pop_front();
        if (rsp_ch.data.feature_index !== exp_item.feature_index)
          report("feature_index", rsp_ch.data.feature_index, exp_item.feature_index);
        if (rsp_ch.data.status !== exp_item.status)
          report("status", rsp_ch.data.status, exp_item.status);
        if (rsp_ch.data.last !== exp_item.last)
          report("last", rsp_ch.data.last, exp_item.last);
      end
    end
  end

  // result side stalls
  initial begin
    int gap;
    rsp_ch.ready = 1'b0;
    @(negedge rst);
    forever begin
      rsp_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      gap = pick_gap();
      if (gap > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  // watchdog on cycles with nothing accepted
  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // inserts at the extremes, cell full, every opcode, level windows, empty box
  task automatic test_directed();
    for (int i = 0; i < 9; i++) send_item(mk(OP_INSERT, 805, 405, i % 8));
    send_item(mk(OP_INSERT, -32768, -32768, 7));
    send_item(mk(OP_INSERT, 32767, 32767, 0));
    send_item(mk(OP_INSERT, 0, 0, 3));
    send_item(mk(OP_INSERT, 10159, 7599, 5));
    send_item(mk(OP_UNUSED, -1, -1, 7, 65535, 7, -1));
    send_item(mk(OP_QUERY, 805, 405, 0, 0));
    send_item(mk(OP_QUERY, 805, 405, 0, 16, 2, 5));
    send_item(mk(OP_QUERY, 805, 405, 0, 16, 0, -1));
    send_item(mk(OP_QUERY, 805, 405, 0, 16, 0, -8));
    send_item(mk(OP_QUERY, -32768, -32768, 0, 16));
    send_item(mk(OP_QUERY, 32767, 32767, 0, 16, 7, 7));
    send_item(mk(OP_QUERY, 5000, 4000, 0, 65535));
    send_item(mk(OP_CLEAR, 0, 0));
    send_item(mk(OP_QUERY, 805, 405, 0, 400));
    drain();
  endtask

  // more matches than fit in one answer
  task automatic test_truncation();
    send_item(mk(OP_CLEAR, 0, 0));
    for (int i = 0; i < 72; i++)
      send_item(mk(OP_INSERT, 80 + 160 * (i % 9) + i, 80 + 160 * (i / 9) + i, i % 8));
    send_item(mk(OP_QUERY, 720, 640, 0, 2000));
    send_item(mk(OP_QUERY, 720, 640, 0, 2000, 4, 7));
    drain();
  endtask

  // grid settings, extremes included
  task automatic test_config_sweep();
    logic [15:0] sets [5][4] = '{
      '{16'h8000, 16'h8000, 16'hFFFF, 16'hFFFF},
      '{16'h7FFF, 16'h7FFF, 16'h0000, 16'h0000},
      '{16'hFF00, 16'h0100, 16'd200, 16'd30000},
      '{16'h8000, 16'h7FFF, 16'd1, 16'hFFFF},
      '{16'h0000, 16'h0000, INV_CELL_RESET, INV_CELL_RESET}};
    foreach (sets[s]) begin
      set_grid(sets[s][0], sets[s][1], sets[s][2], sets[s][3]);
      send_item(mk(OP_CLEAR, 0, 0));
      for (int i = 0; i < 14; i++) send_item(rand_insert());
      for (int i = 0; i < 5; i++) send_item(rand_query(i == 4));
    end
    drain();
  endtask

  // random mix of well-formed traffic with some noise
  task automatic test_random(int count);
    int r;
    send_item(mk(OP_CLEAR, 0, 0));
    for (int i = 0; i < count; i++) begin
      if (i % 60 == 0) steady = ~steady;
      r = $urandom_range(0, 99);
      if (r < 50) send_item(rand_insert());
      else if (r < 88) send_item(rand_query(0));
      else if (r < 91) send_item(rand_query(1));
      else if (r < 93) send_item(mk(OP_CLEAR, 0, 0));
      else send_item(mk($urandom_range(1, 3), $urandom_range(0, 65535),
                        $urandom_range(0, 65535), $urandom_range(0, 7),
                        $urandom_range(0, 65535), $urandom_range(0, 7),
                        $urandom_range(0, 15)));
    end
    steady = 0;
    drain();
  endtask

  initial begin
    org_x = '0;
    org_y = '0;
    inv_w = INV_CELL_RESET;
    inv_h = INV_CELL_RESET;
    pt_count = 0;
    foreach (fill[k]) fill[k] = 0;
    req_ch.valid = 1'b0;
    req_ch.data = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_truncation();
    test_config_sweep();
    set_grid(16'h0000, 16'h0000, INV_CELL_RESET, INV_CELL_RESET);
    test_random(170);
    repeat (50) @(posedge clk);
    $display("covered %0d items, %0d results: %0d hits, %0d truncated answers,",
             n_items, n_results, n_hits, n_trunc);
    $display("  %0d outside-grid and %0d full-cell or full-store inserts, %0d errors",
             n_outside, n_full, errors);
    if (errors == 0 && expected_q.size() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
